/* hw/rtl/bgms_pkg.sv */
// Shared types and constants for the binary grid majority smoothing block.
package bgms_pkg;

   localparam int CRD_W = 6;
   localparam int CNT_W = 4;
   localparam int THR_W = 4;

   localparam logic [THR_W-1:0] THR_RESET = 4'd4;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_PASS  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic ANS_READ = 1'b0;
   localparam logic ANS_PASS = 1'b1;

   // neighbour offsets along one axis
   localparam logic [1:0] OFS_ZERO  = 2'd0;
   localparam logic [1:0] OFS_MINUS = 2'd1;
   localparam logic [1:0] OFS_PLUS  = 2'd2;

   // tap 0 is the cell itself, taps 1 to 8 are its neighbours
   localparam int TAP_W = 4;
   localparam logic [TAP_W-1:0] TAP_SELF = 4'd0;
   localparam logic [TAP_W-1:0] TAP_LAST = 4'd8;

   localparam logic [1:0] TAP_DX [9] = '{
      OFS_ZERO, OFS_MINUS, OFS_MINUS, OFS_MINUS, OFS_ZERO,
      OFS_ZERO, OFS_PLUS, OFS_PLUS, OFS_PLUS
   };
   localparam logic [1:0] TAP_DY [9] = '{
      OFS_ZERO, OFS_MINUS, OFS_ZERO, OFS_PLUS, OFS_MINUS,
      OFS_PLUS, OFS_MINUS, OFS_ZERO, OFS_PLUS
   };

   typedef struct packed {
      logic [1:0]       command;
      logic [CRD_W-1:0] cell_x;
      logic [CRD_W-1:0] cell_y;
      logic             cell_in;
   } req_word_type;

   typedef struct packed {
      logic answer_kind;
      logic cell_out;
      logic any_changed;
   } rsp_word_type;

   typedef struct packed {
      logic done;
      logic changed;
   } pass_stat_type;

endpackage

/* hw/rtl/bgms_grid.sv */
// Cell store: one write port and one registered read port.
module bgms_grid #(
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic              wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic              rd_data
);

   logic cells_ff [2**ADDR_W];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= cells_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/bgms_pass.sv */
// Smoothing pass sequencer: walks the grid, reads nine taps per cell, flips in place.
module bgms_pass
   import bgms_pkg::*;
#(
   parameter int GRID_SIZE = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [THR_W-1:0]            threshold,
   input  logic                        rd_data,
   output logic                        rd_en,
   output logic [2*$clog2(GRID_SIZE)-1:0] rd_addr,
   output logic                        wr_en,
   output logic [2*$clog2(GRID_SIZE)-1:0] wr_addr,
   output logic                        wr_data,
   output pass_stat_type               stat
);

   localparam int CW = $clog2(GRID_SIZE);
   localparam logic [CW-1:0] LAST_IDX = CW'(GRID_SIZE - 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_READ   = 2'd1;
   localparam logic [1:0] S_LAST   = 2'd2;
   localparam logic [1:0] S_DECIDE = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CW-1:0]    cx_ff, cx_in, cy_ff, cy_in;
   logic [TAP_W-1:0] tap_ff, tap_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             self_ff, self_in;
   logic             pend_ff, pend_in;
   logic             pend_self_ff, pend_self_in;
   logic             chg_ff, chg_in;

   logic [CW-1:0] xm, xp, ym, yp, tx, ty;
   logic          flip;

   assign xm = (cx_ff == '0) ? LAST_IDX : cx_ff - CW'(1);
   assign xp = (cx_ff == LAST_IDX) ? '0 : cx_ff + CW'(1);
   assign ym = (cy_ff == '0) ? LAST_IDX : cy_ff - CW'(1);
   assign yp = (cy_ff == LAST_IDX) ? '0 : cy_ff + CW'(1);

   always_comb begin
      case (TAP_DX[tap_ff])
         OFS_MINUS: tx = xm;
         OFS_PLUS:  tx = xp;
         default:   tx = cx_ff;
      endcase
      case (TAP_DY[tap_ff])
         OFS_MINUS: ty = ym;
         OFS_PLUS:  ty = yp;
         default:   ty = cy_ff;
      endcase
   end

   assign flip    = cnt_ff > threshold;
   assign rd_en   = (state_ff == S_READ);
   assign rd_addr = {ty, tx};
   assign wr_en   = (state_ff == S_DECIDE) && flip;
   assign wr_addr = {cy_ff, cx_ff};
   assign wr_data = ~self_ff;

   always_comb begin
      state_in     = state_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      tap_in       = tap_ff;
      cnt_in       = cnt_ff;
      self_in      = self_ff;
      chg_in       = chg_ff;
      pend_in      = rd_en;
      pend_self_in = rd_en && (tap_ff == TAP_SELF);
      stat         = '0;

      // absorb the tap that the store returns this cycle
      if (pend_ff) begin
         if (pend_self_ff) begin
            self_in = rd_data;
         end else if (rd_data != self_ff) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cx_in    = '0;
               cy_in    = '0;
               tap_in   = TAP_SELF;
               cnt_in   = '0;
               chg_in   = 1'b0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            tap_in = tap_ff + TAP_W'(1);
            if (tap_ff == TAP_LAST) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            chg_in   = chg_ff | flip;
            tap_in   = TAP_SELF;
            cnt_in   = '0;
            state_in = S_READ;
            if (cy_ff == LAST_IDX) begin
               cy_in = '0;
               if (cx_ff == LAST_IDX) begin
                  stat.done    = 1'b1;
                  stat.changed = chg_ff | flip;
                  state_in     = S_IDLE;
               end else begin
                  cx_in = cx_ff + CW'(1);
               end
            end else begin
               cy_in = cy_ff + CW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      tap_ff       <= tap_in;
      cnt_ff       <= cnt_in;
      self_ff      <= self_in;
      pend_self_ff <= pend_self_in;
      chg_ff       <= chg_in;
   end

   a_all_taps_in: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE) |-> !pend_ff)
      else $error("decision taken before the last tap arrived");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE) |-> (cnt_ff <= CNT_W'(TAP_LAST)))
      else $error("opposite count above eight");

endmodule

/* hw/rtl/binary_grid_majority_smoothing.sv */
// Top level: command decode, threshold register, cell store and result register.
//
// A square toroidal grid of GRID_SIZE x GRID_SIZE one-bit cells lives in a single-port-read
// memory. After a write word the block is ready again at once; the answer to a read word comes
// back through the store's registered read data and then the result register. A pass word
// makes nine reads per cell through the one read port (itself and its eight wrapped
// neighbours), then waits for the last read to return and takes a decide-and-write step.
// The block stalls its input for the whole pass. Cells have no reset
// value and must be written before they are read or smoothed. A finished result sits in the
// result register until it is taken, and the input stalls while that result is held off.
module binary_grid_majority_smoothing
   import bgms_pkg::*;
#(
   parameter int GRID_SIZE = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_word_type     req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_word_type     rsp_data,
   input  logic             csr_wr_en,
   input  logic [THR_W-1:0] csr_wr_data
);

   localparam int CW     = $clog2(GRID_SIZE);
   localparam int ADDR_W = 2 * CW;

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_READ = 2'd1;
   localparam logic [1:0] T_PASS = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [THR_W-1:0] thr_ff;
   logic             off_ff, off_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_ff, rsp_in;

   logic              accept, on_grid;
   logic [ADDR_W-1:0] cmd_addr;
   logic              g_wr_en, g_wr_data, g_rd_en, g_rd_data;
   logic [ADDR_W-1:0] g_wr_addr, g_rd_addr;
   logic              p_rd_en, p_wr_en, p_wr_data;
   logic [ADDR_W-1:0] p_rd_addr, p_wr_addr;
   pass_stat_type     p_stat;

   assign req_stall = (state_ff != T_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign on_grid   = (int'(req_data.cell_x) < GRID_SIZE) && (int'(req_data.cell_y) < GRID_SIZE);
   assign cmd_addr  = {CW'(req_data.cell_y), CW'(req_data.cell_x)};

   bgms_pass #(
      .GRID_SIZE(GRID_SIZE)
   ) u_pass (
      .clock     (clock),
      .reset     (reset),
      .start     (accept && (req_data.command == CMD_PASS)),
      .threshold (thr_ff),
      .rd_data   (g_rd_data),
      .rd_en     (p_rd_en),
      .rd_addr   (p_rd_addr),
      .wr_en     (p_wr_en),
      .wr_addr   (p_wr_addr),
      .wr_data   (p_wr_data),
      .stat      (p_stat)
   );

   // the pass owns the store while it runs; commands own it otherwise
   always_comb begin
      if (state_ff == T_PASS) begin
         g_wr_en   = p_wr_en;
         g_wr_addr = p_wr_addr;
         g_wr_data = p_wr_data;
         g_rd_en   = p_rd_en;
         g_rd_addr = p_rd_addr;
      end else begin
         g_wr_en   = accept && (req_data.command == CMD_WRITE) && on_grid;
         g_wr_addr = cmd_addr;
         g_wr_data = req_data.cell_in;
         g_rd_en   = accept && (req_data.command == CMD_READ);
         g_rd_addr = cmd_addr;
      end
   end

   bgms_grid #(
      .ADDR_W(ADDR_W)
   ) u_grid (
      .clock   (clock),
      .wr_en   (g_wr_en),
      .wr_addr (g_wr_addr),
      .wr_data (g_wr_data),
      .rd_en   (g_rd_en),
      .rd_addr (g_rd_addr),
      .rd_data (g_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      off_in       = off_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               case (req_data.command)
                  CMD_READ: begin
                     off_in   = !on_grid;
                     state_in = T_READ;
                  end
                  CMD_PASS: begin
                     state_in = T_PASS;
                  end
                  default: begin
                  end
               endcase
            end
         end
         T_READ: begin
            rsp_in.answer_kind = ANS_READ;
            rsp_in.cell_out    = g_rd_data && !off_ff;
            rsp_in.any_changed = 1'b0;
            rsp_valid_in       = 1'b1;
            state_in           = T_IDLE;
         end
         T_PASS: begin
            if (p_stat.done) begin
               rsp_in.answer_kind = ANS_PASS;
               rsp_in.cell_out    = 1'b0;
               rsp_in.any_changed = p_stat.changed;
               rsp_valid_in       = 1'b1;
               state_in           = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         thr_ff       <= THR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
      off_ff <= off_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_pass_out_free: assert property (@(posedge clock) disable iff (reset)
      p_stat.done |-> !rsp_valid_ff)
      else $error("pass finished while the result register was full");

   a_read_out_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == T_READ) |-> !rsp_valid_ff)
      else $error("read answer due while the result register was full");

endmodule
